// ===== sv/point_to_depth_pixel_projection_top_assert.svh =====
// assertion macros for the projection block
`ifndef POINT_TO_DEPTH_PIXEL_PROJECTION_TOP_ASSERT_SVH
`define POINT_TO_DEPTH_PIXEL_PROJECTION_TOP_ASSERT_SVH

// a condition that must hold at every edge out of reset
`define PDP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// an antecedent that must be followed in the next cycle by a consequent
`define PDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/pdp_pkg.sv =====
// shared constants and types for the projection block
package pdp_pkg;

    localparam int CoordFracBits = 8;
    localparam int QuoBits = 44;       // rounded quotient magnitude bits, |q| <= 2^43 + 1
    localparam int NumBits = 48;       // |coord*focal| < 2^48
    localparam int DenBits = 37;       // 2*16*z < 2^37
    localparam int RemBits = DenBits + 1;
    localparam logic [12:0] MaxDim = 13'd4096;

    typedef enum logic [2:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_DEPTH_SCALE = 3'd4,
        REG_IMAGE_WIDTH = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } reg_idx_t;

    // one divider beat travelling down the cell row
    typedef struct packed {
        logic                valid;
        logic [RemBits-1:0]  rem_x;
        logic [RemBits-1:0]  rem_y;
        logic [NumBits:0]    dvd_x;   // 2*|num|+den/2, shifted out msb first
        logic [NumBits:0]    dvd_y;
        logic [QuoBits-1:0]  quo_x;
        logic [QuoBits-1:0]  quo_y;
        logic [DenBits-1:0]  den;     // 2*16*z
        logic                neg_x;
        logic                neg_y;
        logic                zpos;
        logic [15:0]         depth;
    } pdp_beat_t;

endpackage

// ===== sv/pdp_div_cell.sv =====
// one restoring-division step for both axes, registered
module pdp_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stall,
    input  pdp_pkg::pdp_beat_t  beat_in,
    output pdp_pkg::pdp_beat_t  beat_out
);
    import pdp_pkg::*;

    pdp_beat_t beat_reg;
    pdp_beat_t beat_next;
    logic [RemBits-1:0] shx;
    logic [RemBits-1:0] shy;
    logic [RemBits-1:0] dext;

    always_comb
    begin
        beat_next = beat_in;
        dext = {1'b0, beat_in.den};
        shx = {beat_in.rem_x[RemBits-2:0], beat_in.dvd_x[NumBits]};
        shy = {beat_in.rem_y[RemBits-2:0], beat_in.dvd_y[NumBits]};
        beat_next.dvd_x = {beat_in.dvd_x[NumBits-1:0], 1'b0};
        beat_next.dvd_y = {beat_in.dvd_y[NumBits-1:0], 1'b0};
        if (shx >= dext)
        begin
            beat_next.rem_x = shx - dext;
            beat_next.quo_x = {beat_in.quo_x[QuoBits-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem_x = shx;
            beat_next.quo_x = {beat_in.quo_x[QuoBits-2:0], 1'b0};
        end
        if (shy >= dext)
        begin
            beat_next.rem_y = shy - dext;
            beat_next.quo_y = {beat_in.quo_y[QuoBits-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem_y = shy;
            beat_next.quo_y = {beat_in.quo_y[QuoBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (!stall)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;
endmodule

// ===== sv/point_to_depth_pixel_projection_top.sv =====
// top level: pinhole projection of a point to a depth pixel
//
//  channel | handshake         | payload
//  in      | in_valid/in_stall | point_x, point_y, point_z
//  out     | out_valid/out_stall| hit, column, row, depth_value
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one point per cycle while not stalled; stages: one front stage with the
// two focal and the depth multiplies, 49 cells of a bit-serial divider row
// (one quotient bit each), and one output stage. reset clears the valid
// bits, loads register defaults. out_stall with out_valid freezes the row.
module point_to_depth_pixel_projection_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [11:0]         column,
    output logic [11:0]         row,
    output logic [15:0]         depth_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import pdp_pkg::*;

    localparam int Cells = NumBits + 1;

    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [7:0]  depth_scale_reg;
    logic [12:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg     <= 16'd4595;
            focal_y_reg     <= 16'd4595;
            center_x_reg    <= 16'd5038;
            center_y_reg    <= 16'd3558;
            depth_scale_reg <= 8'd10;
            width_reg       <= 13'd640;
            height_reg      <= 13'd400;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOCAL_X:      focal_x_reg     <= cfg_data[15:0];
                REG_FOCAL_Y:      focal_y_reg     <= cfg_data[15:0];
                REG_CENTER_X:     center_x_reg    <= cfg_data[15:0];
                REG_CENTER_Y:     center_y_reg    <= cfg_data[15:0];
                REG_DEPTH_SCALE:  depth_scale_reg <= cfg_data[7:0];
                REG_IMAGE_WIDTH:  width_reg       <= cfg_data[12:0];
                REG_IMAGE_HEIGHT: height_reg      <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic stall;
    logic out_valid_reg;
    assign stall    = out_valid_reg && out_stall;
    assign in_stall = stall;

    // front stage: products and depth
    pdp_beat_t front_next, front_reg;
    logic signed [48:0] num_x, num_y;
    logic [47:0] mag_x, mag_y;
    logic [39:0] zs;
    logic [DenBits-1:0] den;

    always_comb
    begin
        num_x = 49'(point_x) * $signed({1'b0, focal_x_reg});
        num_y = 49'(point_y) * $signed({1'b0, focal_y_reg});
        mag_x = num_x[48] ? 48'(-num_x) : num_x[47:0];
        mag_y = num_y[48] ? 48'(-num_y) : num_y[47:0];
        den   = {point_z[31:0], 5'd0};
        zs    = 40'(point_z[31:0]) * 40'(depth_scale_reg);
        front_next       = '0;
        front_next.valid = in_valid;
        front_next.den   = den;
        // dividend 2*mag+den/2, divisor den (den already 2*16*z)
        front_next.dvd_x = {mag_x, 1'b0} + 49'(den[DenBits-1:1]);
        front_next.dvd_y = {mag_y, 1'b0} + 49'(den[DenBits-1:1]);
        front_next.neg_x = num_x[48];
        front_next.neg_y = num_y[48];
        front_next.zpos  = !point_z[31] && (point_z != 32'sd0);
        zs = zs >> CoordFracBits;
        front_next.depth = (zs > 40'd65535) ? 16'hffff : zs[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (!stall)
        begin
            front_reg <= front_next;
        end
    end

    pdp_beat_t chain [Cells+1];
    assign chain[0] = front_reg;

    for (genvar i = 0; i < Cells; i++)
    begin : g_cell
        pdp_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stall    (stall),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    pdp_beat_t last;
    assign last = chain[Cells];

    // back end: sign, add centre, truncate, bound check
    logic signed [49:0] sx, sy;
    logic signed [49:0] ux, uy;
    logic [12:0] lim_x, lim_y;
    logic in_x, in_y, hit_next;

    always_comb
    begin
        sx = last.neg_x ? -$signed({2'b0, last.quo_x, 4'd0})
                        : $signed({2'b0, last.quo_x, 4'd0});
        sy = last.neg_y ? -$signed({2'b0, last.quo_y, 4'd0})
                        : $signed({2'b0, last.quo_y, 4'd0});
        sx = sx + $signed({34'd0, center_x_reg});
        sy = sy + $signed({34'd0, center_y_reg});
        ux = sx[49] ? -((-sx) >>> 4) : (sx >>> 4);
        uy = sy[49] ? -((-sy) >>> 4) : (sy >>> 4);
        lim_x = (width_reg > MaxDim) ? MaxDim : width_reg;
        lim_y = (height_reg > MaxDim) ? MaxDim : height_reg;
        in_x = !ux[49] && (ux < $signed({37'd0, lim_x}));
        in_y = !uy[49] && (uy < $signed({37'd0, lim_y}));
        hit_next = last.zpos && in_x && in_y;
    end

    logic        hit_reg;
    logic [11:0] column_reg, row_reg;
    logic [15:0] depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            hit_reg    <= hit_next;
            column_reg <= hit_next ? ux[11:0] : 12'd0;
            row_reg    <= hit_next ? uy[11:0] : 12'd0;
            depth_reg  <= hit_next ? last.depth : 16'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign column      = column_reg;
    assign row         = row_reg;
    assign depth_value = depth_reg;

`include "point_to_depth_pixel_projection_top_assert.svh"

    `PDP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
    `PDP_ASSERT_ALWAYS(a_miss_zero, !(out_valid && !hit) || (depth_value == 16'd0))
    `PDP_ASSERT_ALWAYS(a_stall_link, in_stall == (out_valid && out_stall))
endmodule

// ===== tb/tb_top.sv =====
// testbench for the point to depth pixel projection block
`timescale 1ns / 1ps
module tb_top;
    import pdp_pkg::*;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } point_t;

    typedef struct {
        logic        hit;
        logic [11:0] column;
        logic [11:0] row;
        logic [15:0] depth;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // camera copy held by the predictor
    logic [15:0] cam_fx, cam_fy, cam_cx, cam_cy;
    logic [7:0] cam_scale;
    logic [12:0] cam_w, cam_h;

    point_t pending_points[$];
    pixel_t expected_pixels[$];
    int errors = 0;
    int in_wait = 0;
    int out_wait = 0;
    logic cfg_busy = 1'b0;

    point_to_depth_pixel_projection_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .column(column), .row(row), .depth_value(depth_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one axis: returns -1 when out of bounds, else the pixel index
    function automatic longint map_axis(longint coord, longint z, logic [15:0] focal,
                                        logic [15:0] centre, logic [12:0] lim_in);
        longint num, mag, den, r, s, u, lim;
        num = coord * longint'(focal);
        mag = num < 0 ? -num : num;
        den = z * 16;
        r = (2 * mag + den) / (2 * den);
        if (num < 0)
            r = -r;
        s = r * 16 + longint'(centre);
        u = s >= 0 ? (s >>> 4) : -((-s) >>> 4);
        lim = lim_in > 13'd4096 ? 4096 : longint'(lim_in);
        if (u < 0 || u >= lim)
            return -1;
        return u;
    endfunction

    function automatic pixel_t project_point(point_t p);
        pixel_t res;
        longint u, v, d;
        res = '{1'b0, 12'd0, 12'd0, 16'd0};
        if (p.pz <= 0)
            return res;
        u = map_axis(longint'(p.px), longint'(p.pz), cam_fx, cam_cx, cam_w);
        v = map_axis(longint'(p.py), longint'(p.pz), cam_fy, cam_cy, cam_h);
        if (u < 0 || v < 0)
            return res;
        d = (longint'(p.pz) * longint'(cam_scale)) >>> CoordFracBits;
        if (d > 65535)
            d = 65535;
        res.hit = 1'b1;
        res.column = u[11:0];
        res.row = v[11:0];
        res.depth = d[15:0];
        return res;
    endfunction

    // point driver: the slot is free when idle or when the held beat is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_wait > 0)
                begin
                    in_valid <= 1'b0;
                    in_wait <= in_wait - 1;
                end
                else if (pending_points.size() > 0 && !cfg_busy)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    expected_pixels = {expected_pixels, project_point(p)};
                    point_x <= p.px;
                    point_y <= p.py;
                    point_z <= p.pz;
                    in_valid <= 1'b1;
                    in_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result beat");
                    errors++;
                end
                else
                begin
                    pixel_t e;
                    e = expected_pixels.pop_front();
                    if (hit !== e.hit)
                    begin
                        $error("hit expected %0d actual %0d", e.hit, hit);
                        errors++;
                    end
                    if (column !== e.column)
                    begin
                        $error("column expected %0d actual %0d", e.column, column);
                        errors++;
                    end
                    if (row !== e.row)
                    begin
                        $error("row expected %0d actual %0d", e.row, row);
                        errors++;
                    end
                    if (depth_value !== e.depth)
                    begin
                        $error("depth_value expected %0d actual %0d", e.depth, depth_value);
                        errors++;
                    end
                end
            end
            if (out_wait > 0)
            begin
                out_stall <= 1'b1;
                out_wait <= out_wait - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_wait <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 11) : 0;
            end
        end
    end

    task automatic wait_idle();
        while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // drives one write beat; the caller drops cfg_valid after the last one
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FOCAL_X: cam_fx = val[15:0];
            REG_FOCAL_Y: cam_fy = val[15:0];
            REG_CENTER_X: cam_cx = val[15:0];
            REG_CENTER_Y: cam_cy = val[15:0];
            REG_DEPTH_SCALE: cam_scale = val[7:0];
            REG_IMAGE_WIDTH: cam_w = val[12:0];
            REG_IMAGE_HEIGHT: cam_h = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                              logic [15:0] cy, logic [7:0] sc, logic [12:0] w,
                              logic [12:0] h);
        wait_idle();
        cfg_busy = 1'b1;
        @(posedge clk);
        write_reg(REG_FOCAL_X, 32'(fx));
        write_reg(REG_FOCAL_Y, 32'(fy));
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_DEPTH_SCALE, 32'(sc));
        write_reg(REG_IMAGE_WIDTH, 32'(w));
        write_reg(REG_IMAGE_HEIGHT, 32'(h));
        cfg_valid <= 1'b0;
        cfg_busy = 1'b0;
    endtask

    task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        point_t p;
        p.px = x;
        p.py = y;
        p.pz = z;
        pending_points = {pending_points, p};
    endtask

    // mostly points in front of the camera that land near the image
    task automatic add_random_points(int count);
        int k;
        logic signed [31:0] z, x, y;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0: add_point($urandom, $urandom, $urandom);
                1: add_point($urandom, $urandom, -$signed($urandom_range(0, 1000)));
                default:
                begin
                    z = $urandom_range(1, 1 << $urandom_range(4, 30));
                    x = $signed(z) * ($signed($urandom_range(0, 800)) - 400) / 256;
                    y = $signed(z) * ($signed($urandom_range(0, 800)) - 400) / 256;
                    x = x + $signed($urandom_range(0, 255)) - 128;
                    y = y + $signed($urandom_range(0, 255)) - 128;
                    add_point(x, y, z);
                end
            endcase
        end
    endtask

    initial
    begin
        cam_fx = 16'd4595;
        cam_fy = 16'd4595;
        cam_cx = 16'd5038;
        cam_cy = 16'd3558;
        cam_scale = 8'd10;
        cam_w = 13'd640;
        cam_h = 13'd400;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset camera, axis and field extremes
        add_point(0, 0, 32'sd256);
        add_point(0, 0, 0);
        add_point(0, 0, -32'sd256);
        add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_point(32'sh80000000, 32'sh7fffffff, 32'sd1);
        add_point(0, 0, 32'sh7fffffff);
        add_point(-32'sd80000, -32'sd56000, 32'sd256);
        add_point(32'sd80000, 32'sd56000, 32'sd256);
        add_point(-32'sd1, 32'sd1, 32'sd1);
        add_point(32'sd1000, 32'sd500, 32'sd7000000);
        add_random_points(40);

        // zero size, max scale and focal, centre at top
        set_camera(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd255, 13'd0, 13'd0);
        add_point(0, 0, 32'sd256);
        add_random_points(15);
        // oversized image, max centre, extreme focal
        set_camera(16'hffff, 16'd1, 16'hffff, 16'hffff, 8'd255, 13'h1fff, 13'h1fff);
        add_point(0, 0, 32'sd256);
        add_point(32'sh7fffffff, 32'sh80000000, 32'sd1);
        add_random_points(80);
        // zero focal and scale; then small negative sums round to column 0
        set_camera(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 13'd1, 13'd1);
        add_point(32'sd5, -32'sd5, 32'sd256);
        set_camera(16'd16, 16'd16, 16'd7, 16'd7, 8'd1, 13'd4096, 13'd4096);
        add_point(-32'sd256, -32'sd256, 32'sd256);
        add_point(-32'sd384, -32'sd384, 32'sd256);
        add_random_points(80);
        set_camera(16'd4595, 16'd4595, 16'd5038, 16'd3558, 8'd10, 13'd640, 13'd400);
        add_random_points(200);

        wait_idle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/pdp_pkg.sv
sv/pdp_div_cell.sv
sv/point_to_depth_pixel_projection_top.sv
tb/tb_top.sv
